// ===== hdl/log_entry_oldest_latest_empty_search_assert.svh =====
// assertion macros shared by the search block
`ifndef LOG_ENTRY_OLDEST_LATEST_EMPTY_SEARCH_ASSERT_SVH
`define LOG_ENTRY_OLDEST_LATEST_EMPTY_SEARCH_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define LES_ASSERT_NOW(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// next-cycle implication
`define LES_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

// ===== hdl/les_pkg.sv =====
package les_pkg;

  typedef struct packed {
    logic [7:0] entry_page;
    logic [1:0] entry_slot;
    logic [4:0] stamp_day;
    logic [3:0] stamp_month;
    logic [6:0] stamp_year;
    logic [4:0] stamp_hour;
    logic [5:0] stamp_minute;
    logic       last_entry;
  } entry_t;

  typedef struct packed {
    logic [7:0] oldest_page;
    logic [1:0] oldest_slot;
    logic [7:0] latest_page;
    logic [1:0] latest_slot;
    logic [7:0] empty_page;
    logic [1:0] empty_slot;
    logic       empty_found;
  } report_t;

  typedef struct packed {
    logic [7:0] page;
    logic [1:0] slot;
  } pos_t;

  // year, month, day, hour, minute: compares lexicographically as one number
  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
  } stamp_t;

  localparam stamp_t OLDEST_START = '{
    year:   7'd60,
    month:  4'd12,
    day:    5'd31,
    hour:   5'd23,
    minute: 6'd59
  };

  localparam stamp_t LATEST_START = '0;

endpackage

// ===== hdl/les_track.sv =====
module les_track (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  les_pkg::entry_t   entry,
  output les_pkg::report_t  report
);

  logic             scan_started;
  les_pkg::stamp_t  oldest_stamp;
  les_pkg::pos_t    oldest_pos;
  les_pkg::stamp_t  latest_stamp;
  les_pkg::pos_t    latest_pos;
  les_pkg::pos_t    empty_pos;
  logic             empty_seen;

  les_pkg::stamp_t  oldest_stamp_next;
  les_pkg::pos_t    oldest_pos_next;
  les_pkg::stamp_t  latest_stamp_next;
  les_pkg::pos_t    latest_pos_next;
  les_pkg::pos_t    empty_pos_next;
  logic             empty_seen_next;

  les_pkg::stamp_t  stamp;
  les_pkg::pos_t    pos;
  les_pkg::pos_t    start_pos;
  logic             valid_entry;

  always_comb begin
    stamp = '{year: entry.stamp_year, month: entry.stamp_month, day: entry.stamp_day,
              hour: entry.stamp_hour, minute: entry.stamp_minute};
    pos = '{page: entry.entry_page, slot: entry.entry_slot};
    start_pos = '{page: entry.entry_page, slot: 2'd0};
    valid_entry = (entry.stamp_day != 5'd0);

    // first entry of a scan seeds both positions with its page, slot 0
    oldest_stamp_next = oldest_stamp;
    latest_stamp_next = latest_stamp;
    oldest_pos_next = scan_started ? oldest_pos : start_pos;
    latest_pos_next = scan_started ? latest_pos : start_pos;

    if (valid_entry && (stamp <= oldest_stamp)) begin
      oldest_stamp_next = stamp;
      oldest_pos_next = pos;
    end
    if (valid_entry && (stamp >= latest_stamp)) begin
      latest_stamp_next = stamp;
      latest_pos_next = pos;
    end

    empty_pos_next = empty_seen ? empty_pos : pos;
    empty_seen_next = empty_seen || !valid_entry;

    report = '{oldest_page: oldest_pos_next.page, oldest_slot: oldest_pos_next.slot,
               latest_page: latest_pos_next.page, latest_slot: latest_pos_next.slot,
               empty_page: empty_pos_next.page, empty_slot: empty_pos_next.slot,
               empty_found: empty_seen_next};
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && entry.last_entry)) begin
      scan_started <= 1'b0;
      oldest_stamp <= les_pkg::OLDEST_START;
      oldest_pos <= '0;
      latest_stamp <= les_pkg::LATEST_START;
      latest_pos <= '0;
      empty_pos <= '0;
      empty_seen <= 1'b0;
    end else if (advance) begin
      scan_started <= 1'b1;
      oldest_stamp <= oldest_stamp_next;
      oldest_pos <= oldest_pos_next;
      latest_stamp <= latest_stamp_next;
      latest_pos <= latest_pos_next;
      empty_pos <= empty_pos_next;
      empty_seen <= empty_seen_next;
    end
  end

endmodule

// ===== hdl/log_entry_oldest_latest_empty_search.sv =====
// channel  | signals                          | direction
// entry    | entry_valid, entry_ready, entry  | request in
// report   | report_valid, report_ready, report | result out
//
// one entry per cycle while no report waits on a last entry; an entry is registered,
// then folded into the search state by one compare stage, and a last entry's report
// moves from the entry register into the output register once that register is free.
// rst clears the scan state and both valid flags.
// a waiting report holds a last entry in the entry register, and the input behind it;
// other entries keep flowing.
`include "log_entry_oldest_latest_empty_search_assert.svh"

module log_entry_oldest_latest_empty_search (
  input  logic              clk,
  input  logic              rst,
  input  logic              entry_valid,
  output logic              entry_ready,
  input  les_pkg::entry_t   entry,
  output logic              report_valid,
  input  logic              report_ready,
  output les_pkg::report_t  report
);

  logic              stage_valid;
  les_pkg::entry_t   stage;
  logic              advance;
  logic              emit;
  les_pkg::report_t  result;

  // a last entry needs the output register free before it can retire
  assign advance = stage_valid && (!stage.last_entry || !report_valid || report_ready);
  assign emit = advance && stage.last_entry;
  assign entry_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (entry_valid && entry_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (entry_valid && entry_ready) begin
      stage <= entry;
    end
  end

  les_track u_track (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .entry   (stage),
    .report  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (emit) begin
      report_valid <= 1'b1;
    end else if (report_ready) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      report <= result;
    end
  end

  `LES_ASSERT_NOW(a_stall_blocks_input, stage_valid && !advance, !entry_ready)
  `LES_ASSERT_NEXT(a_last_gives_report, emit, report_valid)
  `LES_ASSERT_NOW(a_report_has_source, $rose(report_valid), $past(emit))
  `LES_ASSERT_NOW(a_only_last_stalls, stage_valid && !stage.last_entry, advance)

endmodule

// ===== verif/tb_log_entry_oldest_latest_empty_search.sv =====
`timescale 1ns / 100ps

module tb_log_entry_oldest_latest_empty_search;

  localparam int ENTRY_COUNT  = 950;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_FROM   = 820;
  localparam int DRAIN_CYCLES = 20;
  localparam int SHOWN_LIMIT  = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int ROW_COUNT    = 21;

  typedef struct packed {
    les_pkg::entry_t  e;
    logic             typed;
    les_pkg::report_t rep;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             entry_valid;
  logic             entry_ready;
  les_pkg::entry_t  entry;
  logic             report_valid;
  logic             report_ready;
  les_pkg::report_t report;

  // page, slot, day, month, year, hour, minute, last
  stim_row_t directed_rows [ROW_COUNT] = '{
    '{'{8'hFF, 2'd3, 5'd31, 4'd12, 7'd60, 5'd23, 6'd59, 1'b1}, 1'b1,
      '{8'hFF, 2'd3, 8'hFF, 2'd3, 8'hFF, 2'd3, 1'b0}},
    '{'{8'hA5, 2'd2, 5'd0, 4'd15, 7'd127, 5'd31, 6'd63, 1'b1}, 1'b1,
      '{8'hA5, 2'd0, 8'hA5, 2'd0, 8'hA5, 2'd2, 1'b1}},
    '{'{8'h5A, 2'd1, 5'd1, 4'd1, 7'd61, 5'd0, 6'd0, 1'b1}, 1'b1,
      '{8'h5A, 2'd0, 8'h5A, 2'd1, 8'h5A, 2'd1, 1'b0}},
    '{'{8'h3C, 2'd3, 5'd31, 4'd15, 7'd127, 5'd31, 6'd63, 1'b1}, 1'b1,
      '{8'h3C, 2'd0, 8'h3C, 2'd3, 8'h3C, 2'd3, 1'b0}},
    '{'{8'h00, 2'd3, 5'd1, 4'd0, 7'd0, 5'd0, 6'd0, 1'b1}, 1'b1,
      '{8'h00, 2'd3, 8'h00, 2'd3, 8'h00, 2'd3, 1'b0}},
    // equal stamps, an empty in the middle
    '{'{8'h10, 2'd0, 5'd15, 4'd6, 7'd60, 5'd12, 6'd30, 1'b0}, 1'b0, '0},
    '{'{8'h10, 2'd1, 5'd15, 4'd6, 7'd60, 5'd12, 6'd30, 1'b0}, 1'b0, '0},
    '{'{8'h10, 2'd2, 5'd0, 4'd0, 7'd0, 5'd0, 6'd0, 1'b0}, 1'b0, '0},
    '{'{8'h10, 2'd3, 5'd15, 4'd6, 7'd60, 5'd12, 6'd30, 1'b1}, 1'b0, '0},
    // each stamp field decides once
    '{'{8'h20, 2'd0, 5'd10, 4'd5, 7'd50, 5'd10, 6'd10, 1'b0}, 1'b0, '0},
    '{'{8'h20, 2'd1, 5'd10, 4'd5, 7'd50, 5'd10, 6'd11, 1'b0}, 1'b0, '0},
    '{'{8'h20, 2'd2, 5'd10, 4'd5, 7'd50, 5'd9, 6'd59, 1'b0}, 1'b0, '0},
    '{'{8'h20, 2'd3, 5'd9, 4'd5, 7'd50, 5'd23, 6'd59, 1'b0}, 1'b0, '0},
    '{'{8'h21, 2'd0, 5'd31, 4'd4, 7'd50, 5'd23, 6'd59, 1'b0}, 1'b0, '0},
    '{'{8'h21, 2'd1, 5'd1, 4'd1, 7'd49, 5'd0, 6'd0, 1'b0}, 1'b0, '0},
    '{'{8'h21, 2'd2, 5'd1, 4'd1, 7'd51, 5'd0, 6'd0, 1'b1}, 1'b0, '0},
    // nothing but empties: oldest and latest fall back to first page, slot 0
    '{'{8'h30, 2'd2, 5'd0, 4'd3, 7'd10, 5'd5, 6'd5, 1'b0}, 1'b0, '0},
    '{'{8'h31, 2'd1, 5'd0, 4'd7, 7'd20, 5'd6, 6'd6, 1'b0}, 1'b0, '0},
    '{'{8'h32, 2'd3, 5'd0, 4'd9, 7'd30, 5'd7, 6'd7, 1'b1}, 1'b1,
      '{8'h30, 2'd0, 8'h30, 2'd0, 8'h30, 2'd2, 1'b1}},
    '{'{8'h40, 2'd1, 5'd0, 4'd0, 7'd0, 5'd0, 6'd0, 1'b0}, 1'b0, '0},
    '{'{8'h40, 2'd2, 5'd31, 4'd12, 7'd99, 5'd23, 6'd59, 1'b1}, 1'b0, '0}
  };

  // search state mirrored from the block
  bit              scan_open;
  les_pkg::stamp_t low_stamp;
  les_pkg::stamp_t high_stamp;
  les_pkg::pos_t   low_pos;
  les_pkg::pos_t   high_pos;
  les_pkg::pos_t   empty_pos;
  bit              empty_hit;

  les_pkg::report_t pending_reports [$];
  int      mismatches = 0;
  int      entries_sent = 0;
  int      cycle_count = 0;
  bit      quiet = 1'b0;
  bit      hold_req = 1'b0;

  log_entry_oldest_latest_empty_search u_dut (
    .clk          (clk),
    .rst          (rst),
    .entry_valid  (entry_valid),
    .entry_ready  (entry_ready),
    .entry        (entry),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .report       (report)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void clear_scan();
    scan_open  = 1'b0;
    low_stamp  = les_pkg::OLDEST_START;
    high_stamp = les_pkg::LATEST_START;
    low_pos    = '0;
    high_pos   = '0;
    empty_pos  = '0;
    empty_hit  = 1'b0;
  endfunction

  function automatic void fold_entry(input les_pkg::entry_t e, output bit done,
                                     output les_pkg::report_t rep);
    les_pkg::stamp_t s;
    les_pkg::pos_t   p;
    s = '{year: e.stamp_year, month: e.stamp_month, day: e.stamp_day,
          hour: e.stamp_hour, minute: e.stamp_minute};
    p = '{page: e.entry_page, slot: e.entry_slot};
    if (!scan_open) begin
      scan_open = 1'b1;
      low_pos   = '{page: e.entry_page, slot: 2'd0};
      high_pos  = low_pos;
    end
    if (e.stamp_day != 5'd0) begin
      // ties go to the later entry on both sides
      if (s <= low_stamp) begin
        low_stamp = s;
        low_pos   = p;
      end
      if (s >= high_stamp) begin
        high_stamp = s;
        high_pos   = p;
      end
    end
    if (!empty_hit) begin
      empty_pos = p;
      empty_hit = (e.stamp_day == 5'd0);
    end
    rep  = '0;
    done = e.last_entry;
    if (done) begin
      rep.oldest_page = low_pos.page;
      rep.oldest_slot = low_pos.slot;
      rep.latest_page = high_pos.page;
      rep.latest_slot = high_pos.slot;
      rep.empty_page  = empty_pos.page;
      rep.empty_slot  = empty_pos.slot;
      rep.empty_found = empty_hit;
      clear_scan();
    end
  endfunction

  task automatic push_entry(input les_pkg::entry_t e, input logic typed,
                            input les_pkg::report_t typed_rep);
    bit               done;
    les_pkg::report_t rep;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      entry_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    entry       <= e;
    entry_valid <= 1'b1;
    do @(posedge clk); while (!entry_ready);
    fold_entry(e, done, rep);
    if (done)
      pending_reports.push_back(typed ? typed_rep : rep);
    entries_sent++;
    if (entries_sent == HOLD_AT)
      hold_req = 1'b1;
    if (entries_sent >= QUIET_FROM)
      quiet = 1'b1;
  endtask

  initial begin
    les_pkg::entry_t e;
    int     scan_len;
    bit     tight;
    rst         = 1'b1;
    entry_valid = 1'b0;
    entry       = '0;
    clear_scan();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < ROW_COUNT; i++)
      push_entry(directed_rows[i].e, directed_rows[i].typed, directed_rows[i].rep);

    while (entries_sent < ENTRY_COUNT) begin
      scan_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      // tight scans crowd the stamps around the oldest start to force ties
      tight = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < scan_len; k++) begin
        e.entry_page = 8'($urandom_range(0, 255));
        e.entry_slot = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0) begin
          e.stamp_day    = 5'($urandom_range(0, 31));
          e.stamp_month  = 4'($urandom_range(0, 15));
          e.stamp_year   = 7'($urandom_range(0, 127));
          e.stamp_hour   = 5'($urandom_range(0, 31));
          e.stamp_minute = 6'($urandom_range(0, 63));
        end else if (tight) begin
          e.stamp_day    = 5'(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(30, 31));
          e.stamp_month  = 4'($urandom_range(11, 12));
          e.stamp_year   = 7'($urandom_range(59, 61));
          e.stamp_hour   = 5'($urandom_range(22, 23));
          e.stamp_minute = 6'($urandom_range(58, 59));
        end else begin
          e.stamp_day    = 5'(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 31));
          e.stamp_month  = 4'($urandom_range(1, 12));
          e.stamp_year   = 7'($urandom_range(0, 99));
          e.stamp_hour   = 5'($urandom_range(0, 23));
          e.stamp_minute = 6'($urandom_range(0, 59));
        end
        e.last_entry = (k == scan_len - 1);
        push_entry(e, 1'b0, '0);
      end
    end

    @(negedge clk);
    entry_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // report side: random stall bursts, one long hold-off to back up the block
  initial begin
    int hold_left;
    int stall_left;
    hold_left    = 0;
    stall_left   = 0;
    report_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        report_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        report_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left   = $urandom_range(0, 7);
        report_ready <= 1'b0;
      end else begin
        report_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    les_pkg::report_t want;
    if (!rst && report_valid && report_ready) begin
      if (pending_reports.size() == 0) begin
        if (mismatches < SHOWN_LIMIT)
          $display("report with none pending: %h", report);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        if (report !== want) begin
          if (mismatches < SHOWN_LIMIT)
            $display({"report mismatch: exp old %h/%0d lat %h/%0d emp %h/%0d/%b,",
                      " got old %h/%0d lat %h/%0d emp %h/%0d/%b"},
                     want.oldest_page, want.oldest_slot, want.latest_page, want.latest_slot,
                     want.empty_page, want.empty_slot, want.empty_found,
                     report.oldest_page, report.oldest_slot, report.latest_page,
                     report.latest_slot, report.empty_page, report.empty_slot,
                     report.empty_found);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
